// ----- src/tsm_pkg.sv -----
// Shared types, codes and constants of the typed stack machine.
package tsm_pkg;

  localparam int unsigned DefStackDepth = 32;
  localparam int unsigned DefPcBits     = 16;

  // Entry types
  localparam logic [1:0] TyStr  = 2'd0;
  localparam logic [1:0] TyBool = 2'd1;
  localparam logic [1:0] TyInt  = 2'd2;
  localparam logic [1:0] TyMark = 2'd3;

  // Opcodes
  localparam logic [4:0] OpPushStr  = 5'd0;
  localparam logic [4:0] OpPushInt  = 5'd1;
  localparam logic [4:0] OpPushBool = 5'd2;
  localparam logic [4:0] OpMarker   = 5'd3;
  localparam logic [4:0] OpRun      = 5'd4;
  localparam logic [4:0] OpJump     = 5'd5;
  localparam logic [4:0] OpJumpZ    = 5'd6;
  localparam logic [4:0] OpJumpNz   = 5'd7;
  localparam logic [4:0] OpDup      = 5'd8;
  localparam logic [4:0] OpDrop     = 5'd9;
  localparam logic [4:0] OpSwap     = 5'd10;
  localparam logic [4:0] OpOver     = 5'd11;
  localparam logic [4:0] OpRot      = 5'd12;
  localparam logic [4:0] OpNot      = 5'd13;
  localparam logic [4:0] OpGe       = 5'd14;
  localparam logic [4:0] OpLe       = 5'd15;
  localparam logic [4:0] OpGt       = 5'd16;
  localparam logic [4:0] OpLt       = 5'd17;
  localparam logic [4:0] OpEq       = 5'd18;
  localparam logic [4:0] OpAdd      = 5'd19;
  localparam logic [4:0] OpSub      = 5'd20;
  localparam logic [4:0] OpMul      = 5'd21;
  localparam logic [4:0] OpDiv      = 5'd22;
  localparam logic [4:0] OpLog      = 5'd23;
  localparam logic [4:0] OpError    = 5'd24;
  localparam logic [4:0] OpPrint    = 5'd25;
  localparam logic [4:0] OpDebug    = 5'd26;

  // Result kinds
  localparam logic [2:0] KindStatus = 3'd0;
  localparam logic [2:0] KindProg   = 3'd1;
  localparam logic [2:0] KindArg    = 3'd2;
  localparam logic [2:0] KindPrint  = 3'd3;
  localparam logic [2:0] KindLog    = 3'd4;
  localparam logic [2:0] KindErrMsg = 3'd5;

  // Error codes
  localparam logic [2:0] ErrNone  = 3'd0;
  localparam logic [2:0] ErrUnder = 3'd1;
  localparam logic [2:0] ErrType  = 3'd2;
  localparam logic [2:0] ErrOp    = 3'd3;
  localparam logic [2:0] ErrDivZ  = 3'd4;
  localparam logic [2:0] ErrOver  = 3'd5;
  localparam logic [2:0] ErrUser  = 3'd6;
  localparam logic [2:0] ErrDebug = 3'd7;

  // ALU operations
  typedef enum logic [2:0] {
    AluAdd = 3'd0,
    AluSub = 3'd1,
    AluMul = 3'd2,
    AluDiv = 3'd3
  } alu_op_e;

  // Request to the shared arithmetic unit
  typedef struct packed {
    logic        start;
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  // Reply from the shared arithmetic unit
  typedef struct packed {
    logic        done;
    logic [31:0] res;
  } alu_rsp_t;

endpackage

// ----- src/tsm_alu.sv -----
// Shared arithmetic unit: add/sub, 8-bit-a-step multiply, bit-serial divide.
module tsm_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsm_pkg::alu_req_t req_i,
  output tsm_pkg::alu_rsp_t rsp_o
);
  import tsm_pkg::*;

  typedef enum logic [3:0] {
    AIdle = 4'b0001,
    AMul  = 4'b0010,
    ADiv  = 4'b0100,
    ADone = 4'b1000
  } alu_state_e;

  alu_state_e  state_q, state_d;
  logic [31:0] acc_q, acc_d;     // product or quotient
  logic [31:0] opa_q, opa_d;     // multiplicand or dividend bits
  logic [31:0] opb_q, opb_d;     // multiplier or divisor magnitude
  logic [32:0] rem_q, rem_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  logic [39:0] part;

  always_comb begin
    rem_sh  = {rem_q[31:0], opa_q[31]};
    rem_sub = rem_sh - {1'b0, opb_q};
    part    = {8'd0, opa_q} * {32'd0, opb_q[7:0]};
  end

  // Sequence the multi-cycle operations
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    unique case (state_q)
      AIdle: begin
        if (req_i.start) begin
          cnt_d = 6'd0;
          case (req_i.op)
            AluAdd: begin
              acc_d   = req_i.a + req_i.b;
              state_d = ADone;
            end
            AluSub: begin
              acc_d   = req_i.a - req_i.b;
              state_d = ADone;
            end
            AluMul: begin
              acc_d   = '0;
              opa_d   = req_i.a;
              opb_d   = req_i.b;
              state_d = AMul;
            end
            default: begin
              acc_d   = '0;
              rem_d   = '0;
              opa_d   = req_i.a[31] ? (32'd0 - req_i.a) : req_i.a;
              opb_d   = req_i.b[31] ? (32'd0 - req_i.b) : req_i.b;
              neg_d   = req_i.a[31] ^ req_i.b[31];
              state_d = ADiv;
            end
          endcase
        end
      end
      AMul: begin
        acc_d = acc_q + part[31:0];
        opa_d = {opa_q[23:0], 8'd0};
        opb_d = {8'd0, opb_q[31:8]};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd3) begin
          state_d = ADone;
        end
      end
      ADiv: begin
        opa_d = {opa_q[30:0], 1'b0};
        if (!rem_sub[32]) begin
          rem_d = rem_sub;
          acc_d = {acc_q[30:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          acc_d = {acc_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = ADone;
        end
      end
      ADone: begin
        if (neg_q) begin
          acc_d = 32'd0 - acc_q;
        end
        neg_d   = 1'b0;
        state_d = AIdle;
      end
      default: state_d = AIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AIdle;
      neg_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      neg_q   <= neg_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    opa_q <= opa_d;
    opb_q <= opb_d;
    rem_q <= rem_d;
  end

  // Result is the corrected accumulator, valid in the finishing state
  always_comb begin
    rsp_o.done = (state_q == ADone);
    rsp_o.res  = neg_q ? (32'd0 - acc_q) : acc_q;
  end

endmodule

// ----- src/typed_stack_machine_execute.sv -----
// Top level of the typed stack machine: sequencer, operand stack and result port.
//
//  channel | signals                                         | direction | beat
//  command | start, busy, opcode_i .. string_handle_i        | in        | start & !busy
//  result  | result_valid_o, result_kind_o .. last_o         | out       | result_valid_o
//
// A simple op reads the top three entries one a cycle, executes, reads the new top
// back and shows its beat; the next command is taken only after that beat is shown.
// Swap adds state SWr1, rot SWr2 and SWr1; add/sub, mul and div wait in SAlu on the shared
// unit (8-bit multiply steps, bit-serial divide). A halted block answers via STop and SOut.
// A run scans down to the marker, then shows one beat per entry above it, one a cycle,
// each carrying the final pc, depth and top. Stack reads have registered data.
// Reset clears pointer, pc and error; stack contents are left unset.
// Results are shown for one cycle each; the receiver cannot stall them.
module typed_stack_machine_execute #(
  parameter int unsigned STACK_DEPTH = tsm_pkg::DefStackDepth,
  parameter int unsigned PC_BITS     = tsm_pkg::DefPcBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [4:0]          opcode_i,
  input  logic signed [31:0]  immediate_i,
  input  logic [15:0]         jump_target_i,
  input  logic [15:0]         string_handle_i,
  output logic                result_valid_o,
  output logic [2:0]          result_kind_o,
  output logic [15:0]         handle_o,
  output logic [15:0]         next_pc_o,
  output logic [2:0]          error_code_o,
  output logic [5:0]          stack_depth_o,
  output logic [1:0]          top_type_o,
  output logic signed [31:0]  top_value_o,
  output logic                last_o
);
  import tsm_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);

  typedef enum logic [11:0] {
    SIdle  = 12'b000000000001,
    SRd1   = 12'b000000000010,  // read top
    SRd2   = 12'b000000000100,  // read second
    SRd3   = 12'b000000001000,  // read third
    SExec  = 12'b000000010000,
    SWr1   = 12'b000000100000,
    SWr2   = 12'b000001000000,
    SAlu   = 12'b000010000000,
    SScan  = 12'b000100000000,
    SEmit  = 12'b001000000000,
    STop   = 12'b010000000000,
    SOut   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Operand stack memory
  logic [33:0] mem [STACK_DEPTH];
  logic [33:0] rd_q;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [33:0]   wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // Architectural state and item registers
  logic [5:0]         sp_q, sp_d;
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic [2:0]         herr_q, herr_d;
  logic [4:0]         op_q, op_d;
  logic [31:0]        imm_q, imm_d;
  logic [PC_BITS-1:0] tgt_q, tgt_d;
  logic [15:0]        sh_q, sh_d;
  logic [33:0]        e1_q, e1_d, e2_q, e2_d, e3_q, e3_d;
  logic [5:0]         idx_q, idx_d;      // scan / emit index
  logic [5:0]         base_q, base_d;
  logic [5:0]         lim_q, lim_d;      // depth before a run, end of the emit walk
  logic               found_q, found_d;
  logic               terr_q, terr_d;
  logic [2:0]         kind_q, kind_d;
  logic [15:0]        hnd_q, hnd_d;
  logic               rv_q, rv_d;
  logic               last_q, last_d;
  logic [1:0]         ttype_q, ttype_d;
  logic [31:0]        tval_q, tval_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  tsm_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  logic [PC_BITS-1:0] pc_inc;
  logic               lt_ab, lt_ba, eq_ab;
  logic [31:0]        va, vb;
  logic [5:0]         need;
  logic               two_int;

  always_comb begin
    pc_inc  = pc_q + {{(PC_BITS-1){1'b0}}, 1'b1};
    va      = e2_q[31:0];
    vb      = e1_q[31:0];
    lt_ab   = $signed(va) < $signed(vb);
    lt_ba   = $signed(vb) < $signed(va);
    eq_ab   = (va == vb);
    two_int = (e1_q[33:32] == TyInt) && (e2_q[33:32] == TyInt);
    if (op_q == OpRot) begin
      need = 6'd3;
    end else if (op_q == OpSwap || op_q == OpOver ||
                 (op_q >= OpGe && op_q <= OpDiv)) begin
      need = 6'd2;
    end else begin
      need = 6'd1;
    end
  end

  // Sequence one instruction
  always_comb begin
    state_d = state_q;
    sp_d = sp_q;  pc_d = pc_q;  herr_d = herr_q;
    op_d = op_q;  imm_d = imm_q;  tgt_d = tgt_q;  sh_d = sh_q;
    e1_d = e1_q;  e2_d = e2_q;  e3_d = e3_q;
    idx_d = idx_q;  base_d = base_q;  lim_d = lim_q;  found_d = found_q;  terr_d = terr_q;
    kind_d = kind_q;  hnd_d = hnd_q;  last_d = last_q;
    ttype_d = ttype_q;  tval_d = tval_q;
    rv_d = 1'b0;
    raddr = AW'(sp_q - 6'd1);
    waddr = AW'(sp_q);
    wdata = e1_q;
    we    = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = AluAdd;
    alu_req.a     = va;
    alu_req.b     = vb;

    unique case (state_q)
      SIdle: begin
        if (start && !busy) begin
          op_d   = opcode_i;
          imm_d  = immediate_i;
          tgt_d  = PC_BITS'(jump_target_i);
          sh_d   = string_handle_i;
          kind_d = KindStatus;
          hnd_d  = '0;
          last_d = 1'b1;
          if (herr_q != ErrNone) begin
            state_d = STop;
          end else if (opcode_i == OpRun) begin
            idx_d   = sp_q;
            found_d = 1'b0;
            terr_d  = 1'b0;
            base_d  = 6'd0;
            state_d = (sp_q == 6'd0) ? SExec : SScan;
          end else begin
            state_d = SRd1;
          end
        end
      end
      SRd1: begin
        raddr   = AW'(sp_q - 6'd1);
        state_d = SRd2;
      end
      SRd2: begin
        e1_d    = rd_q;
        raddr   = AW'(sp_q - 6'd2);
        state_d = SRd3;
      end
      SRd3: begin
        e2_d    = rd_q;
        raddr   = AW'(sp_q - 6'd3);
        state_d = SExec;
      end
      SExec: begin
        e3_d    = rd_q;
        state_d = STop;
        if (op_q <= OpMarker) begin
          if (sp_q >= 6'(STACK_DEPTH)) begin
            herr_d = ErrOver;
          end else begin
            we = 1'b1;
            waddr = AW'(sp_q);
            case (op_q)
              OpPushStr:  wdata = {TyStr, 16'd0, sh_q};
              OpPushInt:  wdata = {TyInt, imm_q};
              OpPushBool: wdata = {TyBool, 31'd0, (imm_q != 32'd0)};
              default:    wdata = {TyMark, 32'd0};
            endcase
            sp_d = sp_q + 6'd1;
            pc_d = pc_inc;
          end
        end else if (op_q == OpRun) begin
          // Scan result: underflow, type error, or cut the stack and emit
          if (sp_q == 6'd0 || base_q >= sp_q) begin
            herr_d = ErrUnder;
          end else if (terr_q) begin
            herr_d = ErrType;
          end else begin
            lim_d  = sp_q;
            kind_d = KindProg;
            sp_d   = found_q ? base_q - 6'd1 : 6'd0;
            pc_d   = pc_inc;
          end
        end else if (op_q == OpJump) begin
          pc_d = tgt_q;
        end else if (op_q >= OpLog && op_q <= OpPrint) begin
          if (sp_q < 6'd1) begin
            herr_d = ErrUnder;
          end else if (e1_q[33:32] != TyStr) begin
            herr_d = ErrType;
          end else begin
            hnd_d = e1_q[15:0];
            sp_d  = sp_q - 6'd1;
            if (op_q == OpLog) begin
              kind_d = KindLog;
              pc_d   = pc_inc;
            end else if (op_q == OpPrint) begin
              kind_d = KindPrint;
              pc_d   = pc_inc;
            end else begin
              kind_d = KindErrMsg;
              herr_d = ErrUser;
            end
          end
        end else if (op_q == OpDebug) begin
          herr_d = ErrDebug;
        end else if (op_q > OpDebug) begin
          herr_d = ErrOp;
        end else if (sp_q < need) begin
          herr_d = ErrUnder;
        end else begin
          unique case (op_q)
            OpJumpZ, OpJumpNz: begin
              if (e1_q[33:32] != TyBool) begin
                herr_d = ErrType;
              end else begin
                sp_d = sp_q - 6'd1;
                pc_d = (((op_q == OpJumpZ) == (e1_q[31:0] == 32'd0))) ? tgt_q : pc_inc;
              end
            end
            OpDup, OpOver: begin
              if (sp_q >= 6'(STACK_DEPTH)) begin
                herr_d = ErrOver;
              end else begin
                we    = 1'b1;
                wdata = (op_q == OpDup) ? e1_q : e2_q;
                sp_d  = sp_q + 6'd1;
                pc_d  = pc_inc;
              end
            end
            OpDrop: begin
              sp_d = sp_q - 6'd1;
              pc_d = pc_inc;
            end
            OpSwap: begin
              we    = 1'b1;
              waddr = AW'(sp_q - 6'd1);
              wdata = e2_q;
              e2_d  = e1_q;
              state_d = SWr1;
            end
            OpRot: begin
              // ( x1 x2 x3 -- x2 x3 x1 ): e3=x1 e2=x2 e1=x3
              we    = 1'b1;
              waddr = AW'(sp_q - 6'd1);
              wdata = rd_q;
              state_d = SWr2;
            end
            OpNot: begin
              if (e1_q[33:32] != TyBool) begin
                herr_d = ErrType;
              end else begin
                we    = 1'b1;
                waddr = AW'(sp_q - 6'd1);
                wdata = {TyBool, 31'd0, (e1_q[31:0] == 32'd0)};
                pc_d  = pc_inc;
              end
            end
            default: begin
              if (!two_int) begin
                herr_d = ErrType;
              end else if (op_q >= OpAdd) begin
                if (op_q == OpDiv && vb == 32'd0) begin
                  herr_d = ErrDivZ;
                end else begin
                  alu_req.start = 1'b1;
                  case (op_q)
                    OpAdd:   alu_req.op = AluAdd;
                    OpSub:   alu_req.op = AluSub;
                    OpMul:   alu_req.op = AluMul;
                    default: alu_req.op = AluDiv;
                  endcase
                  state_d = SAlu;
                end
              end else begin
                we    = 1'b1;
                waddr = AW'(sp_q - 6'd2);
                case (op_q)
                  OpGe:    wdata = {TyBool, 31'd0, !lt_ab};
                  OpLe:    wdata = {TyBool, 31'd0, !lt_ba};
                  OpGt:    wdata = {TyBool, 31'd0, lt_ba};
                  OpLt:    wdata = {TyBool, 31'd0, lt_ab};
                  default: wdata = {TyBool, 31'd0, eq_ab};
                endcase
                sp_d = sp_q - 6'd1;
                pc_d = pc_inc;
              end
            end
          endcase
        end
      end
      SWr1: begin
        we      = 1'b1;
        waddr   = AW'(sp_q - 6'd2);
        wdata   = e2_q;
        pc_d    = pc_inc;
        state_d = STop;
      end
      SWr2: begin
        // Put x2 at the bottom of the three, then x3 in the middle
        we      = 1'b1;
        waddr   = AW'(sp_q - 6'd3);
        wdata   = e2_q;
        state_d = SWr1;
        e2_d    = e1_q;
      end
      SAlu: begin
        if (alu_rsp.done) begin
          we      = 1'b1;
          waddr   = AW'(sp_q - 6'd2);
          wdata   = {TyInt, alu_rsp.res};
          sp_d    = sp_q - 6'd1;
          pc_d    = pc_inc;
          state_d = STop;
        end
      end
      SScan: begin
        // Walk down from the top: issue read of idx-1, inspect the previous one
        raddr = AW'(idx_q - 6'd1);
        if (idx_q != sp_q) begin
          if (rd_q[33:32] == TyMark) begin
            found_d = 1'b1;
            base_d  = idx_q + 6'd1;
          end else if (rd_q[33:32] != TyStr) begin
            terr_d = 1'b1;
          end
        end
        if (rd_q[33:32] == TyMark && idx_q != sp_q) begin
          state_d = SExec;
        end else if (idx_q == 6'd0) begin
          state_d = SExec;
        end else begin
          idx_d = idx_q - 6'd1;
        end
        // A last pass with idx at 0 inspects entry 0
        if (idx_q == 6'd0 && sp_q != 6'd0) begin
          state_d = SExec;
        end
      end
      SEmit: begin
        // rd_q holds entry idx; show it and prefetch the next
        raddr  = AW'(idx_q + 6'd1);
        rv_d   = 1'b1;
        kind_d = (idx_q == base_q) ? KindProg : KindArg;
        hnd_d  = rd_q[15:0];
        last_d = (idx_q + 6'd1 == lim_q);
        idx_d  = idx_q + 6'd1;
        if (idx_q + 6'd1 == lim_q) begin
          state_d = SIdle;
        end
      end
      STop: begin
        raddr   = AW'(sp_q - 6'd1);
        state_d = SOut;
      end
      SOut: begin
        ttype_d = (sp_q == 6'd0) ? 2'd0 : rd_q[33:32];
        tval_d  = (sp_q == 6'd0) ? 32'd0 : rd_q[31:0];
        if (op_q == OpRun && kind_q == KindProg) begin
          // Top is latched; start the run beats from the program entry
          idx_d   = base_q;
          raddr   = AW'(base_q);
          state_d = SEmit;
        end else begin
          rv_d    = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  // Run beats carry the top after the whole step; latch it early
  logic [1:0]  emit_type;
  logic [31:0] emit_val;
  logic        emit_pend_q, emit_pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      sp_q    <= '0;
      pc_q    <= '0;
      herr_q  <= ErrNone;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      pc_q    <= pc_d;
      herr_q  <= herr_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  imm_q <= imm_d;  tgt_q <= tgt_d;  sh_q <= sh_d;
    e1_q <= e1_d;  e2_q <= e2_d;  e3_q <= e3_d;
    idx_q <= idx_d;  base_q <= base_d;  lim_q <= lim_d;  found_q <= found_d;
    terr_q <= terr_d;
    kind_q <= kind_d;  hnd_q <= hnd_d;  last_q <= last_d;
    ttype_q <= ttype_d;  tval_q <= tval_d;
  end

  assign emit_type   = ttype_q;
  assign emit_val    = tval_q;
  assign emit_pend_d = 1'b0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_pend_q <= 1'b0;
    end else begin
      emit_pend_q <= emit_pend_d;
    end
  end

  // Drive the result beat
  always_comb begin
    busy           = (state_q != SIdle) || rv_q || emit_pend_q;
    result_valid_o = rv_q;
    result_kind_o  = kind_q;
    handle_o       = hnd_q;
    next_pc_o      = 16'(pc_q);
    error_code_o   = herr_q;
    stack_depth_o  = sp_q;
    top_type_o     = emit_type;
    top_value_o    = emit_val;
    last_o         = last_q;
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench of the typed stack machine: stimulus, prediction and result checks.
`timescale 1ns / 100ps

module tb_top;
  import tsm_pkg::*;

  typedef struct packed {
    logic [4:0]  op;
    logic [31:0] imm;
    logic [15:0] tgt;
    logic [15:0] sh;
  } instr_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] handle;
    logic [15:0] pc;
    logic [2:0]  err;
    logic [5:0]  depth;
    logic [1:0]  ty;
    logic [31:0] val;
    logic        last;
  } beat_t;

  typedef struct packed {
    logic [1:0]  ty;
    logic [31:0] val;
  } entry_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [4:0] opcode = '0;
  logic [31:0] immediate = '0;
  logic [15:0] jump_target = '0;
  logic [15:0] string_handle = '0;
  logic result_valid;
  logic [2:0] result_kind;
  logic [15:0] handle;
  logic [15:0] next_pc;
  logic [2:0] error_code;
  logic [5:0] stack_depth;
  logic [1:0] top_type;
  logic [31:0] top_value;
  logic last;

  instr_t instr_pending[$];
  beat_t  beats_due[$];
  int     fail_count = 0;

  // Shadow machine state
  entry_t      shadow_stack [32];
  int          shadow_sp = 0;
  logic [15:0] shadow_pc = '0;
  logic [2:0]  shadow_err = ErrNone;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typed_stack_machine_execute dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .opcode_i(opcode), .immediate_i(immediate), .jump_target_i(jump_target),
    .string_handle_i(string_handle), .result_valid_o(result_valid),
    .result_kind_o(result_kind), .handle_o(handle), .next_pc_o(next_pc),
    .error_code_o(error_code), .stack_depth_o(stack_depth), .top_type_o(top_type),
    .top_value_o(top_value), .last_o(last)
  );

  // Queue one beat built from the current shadow state
  function automatic void emit_beat(logic [2:0] kind, logic [15:0] h, logic lst);
    beat_t b;
    b.kind = kind;
    b.handle = h;
    b.pc = shadow_pc;
    b.err = shadow_err;
    b.depth = shadow_sp[5:0];
    b.ty = (shadow_sp > 0) ? shadow_stack[shadow_sp-1].ty : 2'd0;
    b.val = (shadow_sp > 0) ? shadow_stack[shadow_sp-1].val : 32'd0;
    b.last = lst;
    beats_due.push_back(b);
  endfunction

  // Execute one instruction on the shadow state and queue its beats
  function automatic void execute_instr(instr_t c);
    logic [15:0] nxt;
    logic [2:0]  err;
    logic [2:0]  kind;
    logic [15:0] h;
    logic [31:0] a, b, r;
    logic        r_bool;
    entry_t      t;
    int          base, n;
    logic [15:0] hs [33];
    nxt = shadow_pc + 16'd1;
    err = ErrNone;
    kind = KindStatus;
    h = '0;
    if (shadow_err != ErrNone) begin
      emit_beat(KindStatus, '0, 1'b1);
      return;
    end
    case (c.op)
      OpPushStr, OpPushInt, OpPushBool, OpMarker: begin
        if (shadow_sp >= 32) err = ErrOver;
        else begin
          case (c.op)
            OpPushStr:  t = '{TyStr, {16'd0, c.sh}};
            OpPushInt:  t = '{TyInt, c.imm};
            OpPushBool: t = '{TyBool, {31'd0, c.imm != 0}};
            default:    t = '{TyMark, 32'd0};
          endcase
          shadow_stack[shadow_sp] = t;
          shadow_sp++;
        end
      end
      OpRun: begin
        base = 0;
        for (int i = shadow_sp; i > 0; i--) begin
          if (shadow_stack[i-1].ty == TyMark) begin
            base = i;
            break;
          end
        end
        if (shadow_sp == 0 || base >= shadow_sp) err = ErrUnder;
        else begin
          for (int i = base; i < shadow_sp; i++)
            if (shadow_stack[i].ty != TyStr) err = ErrType;
        end
        if (err == ErrNone) begin
          n = shadow_sp - base;
          for (int i = 0; i < n; i++) hs[i] = shadow_stack[base+i].val[15:0];
          shadow_sp = (base > 0) ? base - 1 : 0;
          shadow_pc = nxt;
          for (int i = 0; i < n; i++)
            emit_beat((i == 0) ? KindProg : KindArg, hs[i], i + 1 == n);
          return;
        end
      end
      OpJump: nxt = c.tgt;
      OpJumpZ, OpJumpNz: begin
        if (shadow_sp < 1) err = ErrUnder;
        else if (shadow_stack[shadow_sp-1].ty != TyBool) err = ErrType;
        else begin
          r_bool = shadow_stack[shadow_sp-1].val == 0;
          shadow_sp--;
          if ((c.op == OpJumpZ) == r_bool) nxt = c.tgt;
        end
      end
      OpDup, OpOver: begin
        n = (c.op == OpDup) ? 1 : 2;
        if (shadow_sp < n) err = ErrUnder;
        else if (shadow_sp >= 32) err = ErrOver;
        else begin
          shadow_stack[shadow_sp] = shadow_stack[shadow_sp-n];
          shadow_sp++;
        end
      end
      OpDrop: if (shadow_sp < 1) err = ErrUnder; else shadow_sp--;
      OpSwap: begin
        if (shadow_sp < 2) err = ErrUnder;
        else begin
          t = shadow_stack[shadow_sp-1];
          shadow_stack[shadow_sp-1] = shadow_stack[shadow_sp-2];
          shadow_stack[shadow_sp-2] = t;
        end
      end
      OpRot: begin
        if (shadow_sp < 3) err = ErrUnder;
        else begin
          t = shadow_stack[shadow_sp-3];
          shadow_stack[shadow_sp-3] = shadow_stack[shadow_sp-2];
          shadow_stack[shadow_sp-2] = shadow_stack[shadow_sp-1];
          shadow_stack[shadow_sp-1] = t;
        end
      end
      OpNot: begin
        if (shadow_sp < 1) err = ErrUnder;
        else if (shadow_stack[shadow_sp-1].ty != TyBool) err = ErrType;
        else shadow_stack[shadow_sp-1].val = {31'd0, shadow_stack[shadow_sp-1].val == 0};
      end
      OpGe, OpLe, OpGt, OpLt, OpEq, OpAdd, OpSub, OpMul, OpDiv: begin
        if (shadow_sp < 2) err = ErrUnder;
        else if (shadow_stack[shadow_sp-1].ty != TyInt || shadow_stack[shadow_sp-2].ty != TyInt)
          err = ErrType;
        else begin
          a = shadow_stack[shadow_sp-2].val;
          b = shadow_stack[shadow_sp-1].val;
          t.ty = TyBool;
          r = '0;
          case (c.op)
            OpGe: r[0] = $signed(a) >= $signed(b);
            OpLe: r[0] = $signed(a) <= $signed(b);
            OpGt: r[0] = $signed(a) > $signed(b);
            OpLt: r[0] = $signed(a) < $signed(b);
            OpEq: r[0] = a == b;
            default: begin
              t.ty = TyInt;
              case (c.op)
                OpAdd: r = a + b;
                OpSub: r = a - b;
                OpMul: r = a * b;
                default: begin
                  if (b == 0) err = ErrDivZ;
                  else if (a == 32'h8000_0000 && b == 32'hffff_ffff) r = a;
                  else r = $signed(a) / $signed(b);
                end
              endcase
            end
          endcase
          if (err == ErrNone) begin
            t.val = r;
            shadow_stack[shadow_sp-2] = t;
            shadow_sp--;
          end
        end
      end
      OpLog, OpError, OpPrint: begin
        if (shadow_sp < 1) err = ErrUnder;
        else if (shadow_stack[shadow_sp-1].ty != TyStr) err = ErrType;
        else begin
          h = shadow_stack[shadow_sp-1].val[15:0];
          shadow_sp--;
          if (c.op == OpLog) kind = KindLog;
          else if (c.op == OpPrint) kind = KindPrint;
          else begin
            shadow_err = ErrUser;
            emit_beat(KindErrMsg, h, 1'b1);
            return;
          end
        end
      end
      OpDebug: err = ErrDebug;
      default: err = ErrOp;
    endcase
    if (err != ErrNone) shadow_err = err;
    else shadow_pc = nxt;
    emit_beat(kind, h, 1'b1);
  endfunction

  // Queue an instruction; roll back and drop it if it would halt and that is not wanted
  function automatic bit offer(instr_t c, bit halt_ok);
    entry_t      keep_stack [32];
    int          keep_sp, keep_n;
    logic [15:0] keep_pc;
    keep_stack = shadow_stack;
    keep_sp = shadow_sp;
    keep_pc = shadow_pc;
    keep_n = beats_due.size();
    execute_instr(c);
    if (!halt_ok && shadow_err != ErrNone) begin
      shadow_stack = keep_stack;
      shadow_sp = keep_sp;
      shadow_pc = keep_pc;
      shadow_err = ErrNone;
      while (beats_due.size() > keep_n) void'(beats_due.pop_back());
      return 1'b0;
    end
    instr_pending.push_back(c);
    return 1'b1;
  endfunction

  function automatic logic [31:0] rand_int();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 9) - 5;
      default: return $urandom;
    endcase
  endfunction

  function automatic instr_t mk(logic [4:0] op, logic [31:0] imm);
    instr_t c;
    c.op = op;
    c.imm = imm;
    c.tgt = 16'($urandom);
    c.sh = 16'($urandom);
    return c;
  endfunction

  // Random stretch of legal instructions, mostly well-formed sequences
  task automatic fill_random(int count);
    int done_n, k;
    done_n = 0;
    while (done_n < count) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          if (shadow_sp < 27 && offer(mk(OpMarker, '0), 0)) done_n++;
          k = $urandom_range(1, 4);
          for (int i = 0; i < k; i++) if (offer(mk(OpPushStr, '0), 0)) done_n++;
          if (offer(mk(OpRun, '0), 0)) done_n++;
        end
        2, 3: begin
          if (offer(mk(OpPushInt, rand_int()), 0)) done_n++;
          if (offer(mk(OpPushInt, rand_int()), 0)) done_n++;
          if (offer(mk(5'($urandom_range(OpGe, OpDiv)), '0), 0)) done_n++;
          if ($urandom_range(0, 1) && offer(mk(5'($urandom_range(OpJumpZ, OpNot)), '0), 0))
            done_n++;
        end
        4: begin
          if (offer(mk(OpPushStr, '0), 0)) done_n++;
          if (offer(mk($urandom_range(0, 1) ? OpLog : OpPrint, '0), 0)) done_n++;
        end
        5: if (offer(mk(OpPushBool, rand_int()), 0)) done_n++;
        default: if (offer(mk(5'($urandom_range(OpPushStr, OpPrint)), rand_int()), 0)) done_n++;
      endcase
    end
  endtask

  // Wait until every queued instruction is sent and every expected beat has come
  task automatic drain();
    while (instr_pending.size() != 0 || beats_due.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Drive: bursts of commands with random gaps between them
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) void'(instr_pending.pop_front());
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (instr_pending.size() > 0) begin
          start <= 1'b1;
          opcode <= instr_pending[0].op;
          immediate <= instr_pending[0].imm;
          jump_target <= instr_pending[0].tgt;
          string_handle <= instr_pending[0].sh;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 9);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Check each result beat against the oldest expectation
  always @(posedge clk) begin
    beat_t e;
    if (rst_n && result_valid) begin
      if (beats_due.size() == 0) begin
        $error("result beat with none expected, kind %0d", result_kind);
        fail_count++;
      end else begin
        e = beats_due.pop_front();
        if (result_kind !== e.kind) begin
          $error("result_kind exp %0d act %0d", e.kind, result_kind); fail_count++;
        end
        if (handle !== e.handle) begin
          $error("handle exp %0d act %0d", e.handle, handle); fail_count++;
        end
        if (next_pc !== e.pc) begin
          $error("next_pc exp %0d act %0d", e.pc, next_pc); fail_count++;
        end
        if (error_code !== e.err) begin
          $error("error_code exp %0d act %0d", e.err, error_code); fail_count++;
        end
        if (stack_depth !== e.depth) begin
          $error("stack_depth exp %0d act %0d", e.depth, stack_depth); fail_count++;
        end
        if (top_type !== e.ty) begin
          $error("top_type exp %0d act %0d", e.ty, top_type); fail_count++;
        end
        if (top_value !== e.val) begin
          $error("top_value exp %0h act %0h", e.val, top_value); fail_count++;
        end
        if (last !== e.last) begin
          $error("last exp %0d act %0d", e.last, last); fail_count++;
        end
      end
    end
  end

  initial begin
    instr_t c;
    int halt_kind;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: arithmetic extremes, dup, over, rot and swap, runs with and without a marker
    void'(offer(mk(OpPushInt, 32'h8000_0000), 0));
    void'(offer(mk(OpPushInt, 32'hffff_ffff), 0));
    void'(offer(mk(OpDiv, '0), 0));
    void'(offer(mk(OpPushInt, 32'h7fff_ffff), 0));
    void'(offer(mk(OpAdd, '0), 0));
    void'(offer(mk(OpPushInt, -32'sd7), 0));
    void'(offer(mk(OpDiv, '0), 0));
    void'(offer(mk(OpPushInt, 32'd3), 0));
    void'(offer(mk(OpOver, '0), 0));
    void'(offer(mk(OpRot, '0), 0));
    void'(offer(mk(OpMul, '0), 0));
    void'(offer(mk(OpSub, '0), 0));
    void'(offer(mk(OpDup, '0), 0));
    void'(offer(mk(OpEq, '0), 0));
    void'(offer(mk(OpNot, '0), 0));
    c = mk(OpJumpZ, '0); c.tgt = 16'hffff; void'(offer(c, 0));
    c = mk(OpPushBool, 32'h8000_0000); void'(offer(c, 0));
    c = mk(OpJumpNz, '0); c.tgt = 16'h0000; void'(offer(c, 0));
    c = mk(OpPushStr, '0); c.sh = 16'hffff; void'(offer(c, 0));
    c = mk(OpPushStr, '0); c.sh = 16'h0000; void'(offer(c, 0));
    void'(offer(mk(OpSwap, '0), 0));
    void'(offer(mk(OpRun, '0), 0));
    void'(offer(mk(OpMarker, '0), 0));
    void'(offer(mk(OpPushStr, '0), 0));
    void'(offer(mk(OpRun, '0), 0));
    drain();

    // Random phases, with a full pause between them
    for (int p = 0; p < 3; p++) begin
      fill_random(85);
      drain();
    end

    // Close with one halting case, then instructions that the halted block ignores
    while (shadow_sp > 28) void'(offer(mk(OpDrop, '0), 0));
    halt_kind = $urandom_range(0, 6);
    case (halt_kind)
      0: begin
        while (shadow_sp > 0) void'(offer(mk(OpDrop, '0), 0));
        void'(offer(mk(5'($urandom_range(OpRun, OpPrint)), '0), 1));
      end
      1: begin
        while (shadow_sp < 32) void'(offer(mk(OpPushInt, rand_int()), 0));
        void'(offer(mk($urandom_range(0, 1) ? OpDup : OpPushStr, '0), 1));
      end
      2: begin
        void'(offer(mk(OpPushInt, rand_int()), 0));
        void'(offer(mk(OpNot, '0), 1));
      end
      3: begin
        void'(offer(mk(OpPushInt, rand_int()), 0));
        void'(offer(mk(OpPushInt, 32'd0), 0));
        void'(offer(mk(OpDiv, '0), 1));
      end
      4: begin
        void'(offer(mk(OpPushStr, '0), 0));
        void'(offer(mk(OpError, '0), 1));
      end
      5: void'(offer(mk(OpDebug, '0), 1));
      default: void'(offer(mk(5'($urandom_range(27, 31)), '0), 1));
    endcase
    for (int i = 0; i < 6; i++) begin
      c = mk(5'($urandom), $urandom);
      void'(offer(c, 1));
    end
    drain();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop on a hung run
  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
